FILE: sv/kvt_pkg.sv
// shared types and constants of the key/value table
package kvt_pkg;

    localparam int SLOTS   = 16;
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = $clog2(SLOTS + 1);
    localparam int ENTRY_W = 5;

    typedef enum logic [1:0] {
        ACT_PUT     = 2'd0,
        ACT_GET     = 2'd1,
        ACT_DEL     = 2'd2,
        ACT_PUT_NEW = 2'd3
    } action_t;

    // request as held while the cells work on it
    typedef struct packed {
        action_t              action;
        logic [KEY_W-1:0]     key;
        logic [VALUE_W-1:0]   value;
    } req_t;

    // what one cell hands to the next along the row
    typedef struct packed {
        logic                 hit;
        logic [VALUE_W-1:0]   hit_value;
        logic                 free_seen;
    } link_t;

endpackage

FILE: sv/kvt_cell.sv
// one slot of the table: key, value and valid bit with local compare
module kvt_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  kvt_pkg::req_t   req,
    input  logic            exec,
    input  logic            hit_all,
    input  kvt_pkg::link_t  link_in,
    output kvt_pkg::link_t  link_out,
    output logic            match
);

    logic                        valid_reg;
    logic [kvt_pkg::KEY_W-1:0]   key_reg;
    logic [kvt_pkg::VALUE_W-1:0] value_reg;
    logic                        is_insert;
    logic                        take_new;

    assign match = valid_reg && (key_reg == req.key);

    assign link_out.hit       = link_in.hit | match;
    assign link_out.hit_value = link_in.hit_value | (match ? value_reg : '0);
    assign link_out.free_seen = link_in.free_seen | !valid_reg;

    assign is_insert = (req.action == kvt_pkg::ACT_PUT) || (req.action == kvt_pkg::ACT_PUT_NEW);
    // first free slot in the row takes a new key
    assign take_new  = is_insert && !hit_all && !valid_reg && !link_in.free_seen;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (exec) begin
            if (take_new) begin
                valid_reg <= 1'b1;
            end else if (req.action == kvt_pkg::ACT_DEL && match) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            if (take_new) begin
                key_reg   <= req.key;
                value_reg <= req.value;
            end else if (req.action == kvt_pkg::ACT_PUT && match) begin
                value_reg <= req.value;
            end
        end
    end

endmodule

FILE: sv/key_value_table_core.sv
// top level of the key/value table: request register, row of slot cells, result register
//
//  channel   | dir | beat contents
//  s_axis    | in  | one request: action, key, value
//  m_axis    | out | one result: found, old_value, inserted, full_error, entry_count, is_empty
//
// a request is first registered, then the compare and update ripple along the row
// of SLOTS cells (match, first free slot, old value)
// s_axis_tready is low while a request is held, so no new beat is taken until it is done
// a result waiting on m_axis_tready holds the next request, which keeps s_axis_tready low
// reset clears all slot valid bits, the pair count and both valid flags at once
module key_value_table_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // action[1:0], key[33:2], value[65:34], zero[71:66]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // found[0], old_value[32:1], inserted[33],
                                        // full_error[34], entry_count[39:35], is_empty[40]
);

    localparam int N = kvt_pkg::SLOTS;
    localparam int CW = kvt_pkg::COUNT_W;

    // request register
    logic             req_valid_reg;
    kvt_pkg::req_t    req_reg;
    logic             s_fire;
    logic             exec;

    // row of cells
    kvt_pkg::link_t   links [0:N];
    logic [N-1:0]     match_vec;
    logic             hit_all;
    logic             free_any;

    // result path
    logic             is_insert;
    logic             inserted;
    logic             full_err;
    logic             deleted;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [CW+4:0]    count_ext;
    logic             m_valid_reg;
    logic [47:0]      m_data_reg;
    logic [47:0]      m_data_next;

    assign s_axis_tready = !req_valid_reg;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    // the row updates once the result register can take the outcome
    assign exec          = req_valid_reg && (!m_valid_reg || m_axis_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else if (s_fire) begin
            req_valid_reg <= 1'b1;
        end else if (exec) begin
            req_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg.action <= kvt_pkg::action_t'(s_axis_tdata[1:0]);
            req_reg.key    <= s_axis_tdata[33:2];
            req_reg.value  <= s_axis_tdata[65:34];
        end
    end

    // row of slots, lowest slot first so the first free one wins
    assign links[0] = '0;

    for (genvar i = 0; i < N; i++) begin : g_cell
        kvt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .req      (req_reg),
            .exec     (exec),
            .hit_all  (hit_all),
            .link_in  (links[i]),
            .link_out (links[i+1]),
            .match    (match_vec[i])
        );
    end

    assign hit_all  = links[N].hit;
    assign free_any = links[N].free_seen;

    // outcome of the held request
    assign is_insert = (req_reg.action == kvt_pkg::ACT_PUT)
                    || (req_reg.action == kvt_pkg::ACT_PUT_NEW);
    assign inserted  = is_insert && !hit_all && free_any;
    assign full_err  = is_insert && !hit_all && !free_any;
    assign deleted   = (req_reg.action == kvt_pkg::ACT_DEL) && hit_all;

    assign count_next = count_reg + CW'(inserted) - CW'(deleted);
    assign count_ext  = {5'd0, count_next};

    always_comb begin
        m_data_next        = '0;
        m_data_next[0]     = hit_all;
        m_data_next[32:1]  = links[N].hit_value;   // zero when no slot matched
        m_data_next[33]    = inserted;
        m_data_next[34]    = full_err;
        m_data_next[39:35] = count_ext[4:0];
        m_data_next[40]    = (count_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (exec) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // keys stay unique, so at most one slot matches
    a_unique_match: assert property (@(posedge aclk) disable iff (!aresetn)
        req_valid_reg |-> $onehot0(match_vec))
        else $error("more than one slot matches the key");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(N))
        else $error("pair count above slot count");

    a_insert_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec && inserted) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not raise the pair count");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg[40] == (count_reg == '0)))
        else $error("empty flag disagrees with pair count");

    a_full_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec && full_err) |-> (count_reg == CW'(N)))
        else $error("insert refused while a slot is free");

endmodule

FILE: bench/testbench.sv
// self-checking bench for key_value_table_core: directed table, then random traffic
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1925;
    localparam int KEY_POOL_N   = 24;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES  = 150;
    localparam int HOLD_AT      = 400;
    localparam int DIR_N        = 26;

    // one result beat, fields in the order they sit in m_axis_tdata
    typedef struct packed {
        logic                         found;
        logic [kvt_pkg::VALUE_W-1:0]  old_value;
        logic                         inserted;
        logic                         full_error;
        logic [kvt_pkg::ENTRY_W-1:0]  entry_count;
        logic                         is_empty;
    } kv_result_t;

    // directed row: fixed marks a result written out by hand
    typedef struct packed {
        kvt_pkg::action_t             act;
        logic [kvt_pkg::KEY_W-1:0]    key;
        logic [kvt_pkg::VALUE_W-1:0]  value;
        logic                         fixed;
        kv_result_t                   res;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;

    // shadow copy of the table
    logic                        shadow_valid [kvt_pkg::SLOTS];
    logic [kvt_pkg::KEY_W-1:0]   shadow_key   [kvt_pkg::SLOTS];
    logic [kvt_pkg::VALUE_W-1:0] shadow_value [kvt_pkg::SLOTS];
    int                          shadow_count;

    kv_result_t pending_results[$];
    int         mismatch_count;
    int         results_seen;
    int         cycle_count;
    bit         quiet;

    key_value_table_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // applies one request to the shadow table and returns the result it yields
    function automatic kv_result_t predict_table_result(kvt_pkg::action_t act,
                                                        logic [kvt_pkg::KEY_W-1:0] key,
                                                        logic [kvt_pkg::VALUE_W-1:0] value);
        kv_result_t r;
        int hit_slot;
        int free_idx;
        hit_slot = -1;
        free_idx = -1;
        r = '0;
        for (int i = kvt_pkg::SLOTS - 1; i >= 0; i--) begin
            if (shadow_valid[i] && shadow_key[i] == key) hit_slot = i;
            if (!shadow_valid[i]) free_idx = i;
        end
        if (hit_slot >= 0) begin
            r.found     = 1'b1;
            r.old_value = shadow_value[hit_slot];
        end
        case (act)
            kvt_pkg::ACT_PUT, kvt_pkg::ACT_PUT_NEW: begin
                if (hit_slot >= 0) begin
                    if (act == kvt_pkg::ACT_PUT) shadow_value[hit_slot] = value;
                end else if (free_idx >= 0) begin
                    shadow_valid[free_idx] = 1'b1;
                    shadow_key[free_idx]   = key;
                    shadow_value[free_idx] = value;
                    shadow_count++;
                    r.inserted = 1'b1;
                end else begin
                    r.full_error = 1'b1;
                end
            end
            kvt_pkg::ACT_DEL: begin
                if (hit_slot >= 0) begin
                    shadow_valid[hit_slot] = 1'b0;
                    if (shadow_count > 0) shadow_count--;
                end
            end
            default: ;
        endcase
        r.entry_count = shadow_count[kvt_pkg::ENTRY_W-1:0];
        r.is_empty    = (shadow_count == 0);
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic offer_request(kvt_pkg::action_t act, logic [kvt_pkg::KEY_W-1:0] key,
                                 logic [kvt_pkg::VALUE_W-1:0] value, logic fixed,
                                 kv_result_t fixed_res);
        kv_result_t r;
        int gap;
        if (!quiet && $urandom_range(99) < 24) begin
            s_axis_tvalid = 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {6'd0, value, key, act};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        r = predict_table_result(act, key, value);
        pending_results.push_back(fixed ? fixed_res : r);
        @(negedge aclk);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // result side: compare every accepted beat with the oldest prediction
    always @(posedge aclk) begin
        kv_result_t want;
        kv_result_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.found       = m_axis_tdata[0];
            got.old_value   = m_axis_tdata[32:1];
            got.inserted    = m_axis_tdata[33];
            got.full_error  = m_axis_tdata[34];
            got.entry_count = m_axis_tdata[39:35];
            got.is_empty    = m_axis_tdata[40];
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing pending: %h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("found", 32'(want.found), 32'(got.found));
                check_field("old_value", want.old_value, got.old_value);
                check_field("inserted", 32'(want.inserted), 32'(got.inserted));
                check_field("full_error", 32'(want.full_error), 32'(got.full_error));
                check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
                check_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off so the input side backs up
    initial begin
        int hold_left;
        bit held_once;
        hold_left = 0;
        held_once = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_axis_tready = 1'b0;
                hold_left--;
            end else if (!held_once && results_seen >= HOLD_AT) begin
                held_once     = 1'b1;
                hold_left     = HOLD_CYCLES - 1;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = quiet || ($urandom_range(99) >= 24);
            end
        end
    end

    // sender and end of run
    initial begin
        stim_row_t directed_rows [DIR_N];
        logic [kvt_pkg::KEY_W-1:0] key_pool [KEY_POOL_N];
        kvt_pkg::action_t act;
        logic [kvt_pkg::KEY_W-1:0] key;
        logic [kvt_pkg::VALUE_W-1:0] value;
        int roll;
        bit drain;

        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        aresetn        = 1'b0;
        quiet          = 1'b0;
        mismatch_count = 0;
        results_seen   = 0;
        cycle_count    = 0;
        shadow_count   = 0;
        for (int i = 0; i < kvt_pkg::SLOTS; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_key[i]   = '0;
            shadow_value[i] = '0;
        end

        // result fields: found, old_value, inserted, full_error, entry_count, is_empty
        directed_rows = '{
            // empty table right after reset
            '{kvt_pkg::ACT_GET,     32'h0000_0000, 32'h0000_0000, 1'b1,
              '{1'b0, 32'h0, 1'b0, 1'b0, 5'd0, 1'b1}},
            '{kvt_pkg::ACT_DEL,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              '{1'b0, 32'h0, 1'b0, 1'b0, 5'd0, 1'b1}},
            // extreme keys and values
            '{kvt_pkg::ACT_PUT,     32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
              '{1'b0, 32'h0, 1'b1, 1'b0, 5'd1, 1'b0}},
            '{kvt_pkg::ACT_PUT,     32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
              '{1'b0, 32'h0, 1'b1, 1'b0, 5'd2, 1'b0}},
            '{kvt_pkg::ACT_GET,     32'h0000_0000, 32'h1234_5678, 1'b1,
              '{1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 5'd2, 1'b0}},
            // replace returns the previous value
            '{kvt_pkg::ACT_PUT,     32'h0000_0000, 32'h1234_5678, 1'b1,
              '{1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 5'd2, 1'b0}},
            // insert-if-absent on a present key leaves it alone
            '{kvt_pkg::ACT_PUT_NEW, 32'h0000_0000, 32'h0000_0000, 1'b1,
              '{1'b1, 32'h1234_5678, 1'b0, 1'b0, 5'd2, 1'b0}},
            '{kvt_pkg::ACT_PUT_NEW, 32'h0000_0001, 32'hAAAA_AAAA, 1'b0, '0},
            // fill the remaining slots
            '{kvt_pkg::ACT_PUT,     32'h8000_0000, 32'h5555_5555, 1'b0, '0},
            '{kvt_pkg::ACT_PUT,     32'h8000_0001, 32'h0000_0001, 1'b0, '0},
            '{kvt_pkg::ACT_PUT_NEW, 32'h8000_0002, 32'h8000_0000, 1'b0, '0},
            '{kvt_pkg::ACT_PUT,     32'h8000_0003, 32'hDEAD_BEEF, 1'b0, '0},
            '{kvt_pkg::ACT_PUT,     32'h8000_0004, 32'h0F0F_0F0F, 1'b0, '0},
            '{kvt_pkg::ACT_PUT_NEW, 32'h8000_0005, 32'hF0F0_F0F0, 1'b0, '0},
            '{kvt_pkg::ACT_PUT,     32'h8000_0006, 32'h0000_0006, 1'b0, '0},
            '{kvt_pkg::ACT_PUT,     32'h8000_0007, 32'h0000_0007, 1'b0, '0},
            '{kvt_pkg::ACT_PUT,     32'h8000_0008, 32'h0000_0008, 1'b0, '0},
            '{kvt_pkg::ACT_PUT_NEW, 32'h8000_0009, 32'h0000_0009, 1'b0, '0},
            '{kvt_pkg::ACT_PUT,     32'h8000_000A, 32'h0000_000A, 1'b0, '0},
            '{kvt_pkg::ACT_PUT,     32'h8000_000B, 32'h0000_000B, 1'b0, '0},
            '{kvt_pkg::ACT_PUT,     32'h8000_000C, 32'h0000_000C, 1'b0, '0},
            // full table refuses new keys for both insert actions
            '{kvt_pkg::ACT_PUT,     32'h7FFF_FFFF, 32'h0000_0001, 1'b1,
              '{1'b0, 32'h0, 1'b0, 1'b1, 5'd16, 1'b0}},
            '{kvt_pkg::ACT_PUT_NEW, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1,
              '{1'b0, 32'h0, 1'b0, 1'b1, 5'd16, 1'b0}},
            // replace still works when full
            '{kvt_pkg::ACT_PUT,     32'hFFFF_FFFF, 32'h5555_5555, 1'b1,
              '{1'b1, 32'h0, 1'b0, 1'b0, 5'd16, 1'b0}},
            '{kvt_pkg::ACT_DEL,     32'h0000_0000, 32'h0000_0000, 1'b1,
              '{1'b1, 32'h1234_5678, 1'b0, 1'b0, 5'd15, 1'b0}},
            // freed slot is reused
            '{kvt_pkg::ACT_PUT_NEW, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, '0}
        };

        // small key pool so hits, fills and drains all happen
        for (int i = 0; i < KEY_POOL_N; i++) key_pool[i] = $urandom;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[3] = key_pool[2] ^ 32'h8000_0000;
        key_pool[5] = key_pool[4] ^ 32'h0000_0001;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i]) begin
            offer_request(directed_rows[i].act, directed_rows[i].key, directed_rows[i].value,
                          directed_rows[i].fixed, directed_rows[i].res);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = (n >= 900 && n < 1250);
            // alternate insert-heavy and delete-heavy stretches
            drain = ((n / 150) % 2) == 1;
            roll  = $urandom_range(99);
            if (!drain) begin
                if (roll < 35)      act = kvt_pkg::ACT_PUT;
                else if (roll < 65) act = kvt_pkg::ACT_PUT_NEW;
                else if (roll < 85) act = kvt_pkg::ACT_GET;
                else                act = kvt_pkg::ACT_DEL;
            end else begin
                if (roll < 45)      act = kvt_pkg::ACT_DEL;
                else if (roll < 65) act = kvt_pkg::ACT_GET;
                else if (roll < 85) act = kvt_pkg::ACT_PUT;
                else                act = kvt_pkg::ACT_PUT_NEW;
            end
            if ($urandom_range(99) < 85) key = key_pool[$urandom_range(KEY_POOL_N - 1)];
            else                         key = $urandom;
            roll = $urandom_range(99);
            if (roll < 8)       value = 32'h0000_0000;
            else if (roll < 16) value = 32'hFFFF_FFFF;
            else                value = $urandom;
            offer_request(act, key, value, 1'b0, '0);
        end
        quiet = 1'b0;
        s_axis_tvalid = 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/kvt_pkg.sv
sv/kvt_cell.sv
sv/key_value_table_core.sv
bench/testbench.sv
